// ===== hdl/radix_number_to_ascii_top_macros.svh =====
// Assertion macros shared by the radix number to ASCII converter.
`ifndef RADIX_NUMBER_TO_ASCII_TOP_MACROS_SVH
`define RADIX_NUMBER_TO_ASCII_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RNTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RNTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rnta_pkg.sv =====
// Package with character codes, register indexes and the digit encoder.
package rnta_pkg;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_digit;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int BASE_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE = 1'd1;

    localparam logic [BASE_W-1:0] RADIX_RESET = 5'd16;
    localparam logic [BASE_W-1:0] BASE_MIN    = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX    = 5'd16;

    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_X     = 8'h78;
    localparam t_char CHAR_UPPER = 8'h41;
    localparam t_char CHAR_LOWER = 8'h61;

    function automatic t_char digit_char(input t_digit d, input logic upper);
        t_char res;
        if (d < 4'd10) begin
            res = CHAR_ZERO + {4'd0, d};
        end else if (upper) begin
            res = CHAR_UPPER + {4'd0, d} - 8'd10;
        end else begin
            res = CHAR_LOWER + {4'd0, d} - 8'd10;
        end
        return res;
    endfunction

endpackage

// ===== hdl/radix_number_to_ascii_top.sv =====
// Top level: bit-serial radix conversion of an unsigned value into ASCII text.
//
//  Channel   Direction  Payload                                   Handshake
//  s_axis    in         tdata = value                             tvalid/tready
//  m_axis    out        tdata = character, tlast = last_char      tvalid/tready
//  cfg       in         i_cfg_index, i_cfg_data (radix, upper)    i_cfg_valid/o_cfg_ready
//
// Each digit comes from the one-bit-per-cycle restoring divider. The digit store is
// read through one registered port. Reset is synchronous and active low and returns
// the radix to 16 and lower-case letters. A stalled output holds the current
// character and the text sequencer; the input is taken only when idle.
module radix_number_to_ascii_top #(
    parameter  int VALUE_BITS = 48,
    localparam int S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,   // [VALUE_BITS-1:0] value
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] character
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rnta_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rnta_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rnta_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_X     = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;

    logic [2:0]            r_state;
    logic [BASE_W-1:0]     r_radix;
    logic                  r_upper;
    logic [BASE_W-1:0]     r_base;
    logic [VALUE_BITS-1:0] r_quot;
    t_digit                r_rem;
    logic                  r_qnz;
    logic [IDX_W-1:0]      r_bit;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    t_digit                r_rd_data;
    t_digit                r_mem [VALUE_BITS];
    logic                  r_out_valid;
    t_char                 r_out_char;
    logic                  r_out_last;

    logic [BASE_W-1:0]     n_base;
    logic [BASE_W-1:0]     rem_sh;
    logic                  ge;
    t_digit                rem_new;
    logic                  out_free;
    logic                  out_emit;
    logic                  dig_wr;
    logic                  in_div;
    logic                  last_emit;
    logic                  last_shown;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_emit      = out_free && (r_state inside {ST_ZERO, ST_X, ST_DIGIT});

    assign rem_sh  = {r_rem, r_quot[VALUE_BITS-1]};
    assign ge      = (rem_sh >= r_base);
    assign rem_new = ge ? 4'(rem_sh - r_base) : rem_sh[3:0];
    assign dig_wr  = (r_state == ST_DIV) && (r_bit == '0);

    assign in_div     = (r_state == ST_DIV);
    assign last_emit  = out_emit && (r_state == ST_DIGIT) && (r_idx == '0);
    assign last_shown = m_axis_tvalid && m_axis_tlast && (r_state == ST_IDLE);

    always_comb begin
        if (r_radix < BASE_MIN) begin
            n_base = BASE_MIN;
        end else if (r_radix > BASE_MAX) begin
            n_base = BASE_MAX;
        end else begin
            n_base = r_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_upper <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RADIX:      r_radix <= i_cfg_data;
                REG_UPPER_CASE: r_upper <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (dig_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= rem_new;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_quot      <= '0;
        end else begin
            if (out_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_quot  <= s_axis_tdata[VALUE_BITS-1:0];
                        r_rem   <= '0;
                        r_qnz   <= 1'b0;
                        r_bit   <= IDX_W'(VALUE_BITS - 1);
                        r_count <= '0;
                        r_base  <= n_base;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_quot <= {r_quot[VALUE_BITS-2:0], ge};
                    if (r_bit == '0) begin
                        r_count <= r_count + CNT_W'(1);
                        r_rem   <= '0;
                        r_qnz   <= 1'b0;
                        r_bit   <= IDX_W'(VALUE_BITS - 1);
                        if (!(r_qnz || ge)) begin
                            r_state <= ST_ZERO;
                        end
                    end else begin
                        r_rem <= rem_new;
                        r_qnz <= r_qnz || ge;
                        r_bit <= r_bit - IDX_W'(1);
                    end
                end
                ST_ZERO: begin
                    if (out_free) begin
                        r_out_char  <= CHAR_ZERO;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_X;
                    end
                end
                ST_X: begin
                    if (out_free) begin
                        r_out_char  <= CHAR_X;
                        r_out_last  <= 1'b0;
                        r_idx       <= IDX_W'(r_count - CNT_W'(1));
                        r_state     <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_DIGIT;
                end
                ST_DIGIT: begin
                    if (out_free) begin
                        r_out_char  <= digit_char(r_rd_data, r_upper);
                        r_out_last  <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx - IDX_W'(1);
                            r_state <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`include "radix_number_to_ascii_top_macros.svh"

    `RNTA_ASSERT_NOW(a_count_bound, in_div, r_count < CNT_W'(VALUE_BITS), "digit count overflow")
    `RNTA_ASSERT_NOW(a_base_range, in_div, r_base >= BASE_MIN && r_base <= BASE_MAX, "bad base")
    `RNTA_ASSERT_NEXT(a_start_div, s_axis_tvalid && s_axis_tready, in_div, "request not started")
    `RNTA_ASSERT_NEXT(a_last_flag, last_emit, last_shown, "final digit not flagged")

endmodule
